@@ sv/hexc_pkg.sv @@
// Shared types, constants and the slot table for the hex20 connectivity block.
// Used by the modules and interfaces of the block but hexc_queue; depends on nothing.
`default_nettype none

package hexc_pkg;

  localparam int MAX_RES_DEF = 256;
  localparam int RES_W_DEF   = $clog2(MAX_RES_DEF + 2);

  localparam int IDX_W     = 24;
  localparam int NODE_W    = 27;
  localparam int SLOT_W    = 5;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 4;
  localparam int NUM_SLOTS = 20;
  localparam int NUM_KINDS = 4;

  localparam int DIV_STEPS  = 4;
  localparam int DIV_CYCLES = IDX_W / DIV_STEPS;
  localparam int CNT_W      = $clog2(DIV_CYCLES);

  localparam int QUEUE_DEPTH = 2;

  localparam logic [SLOT_W-1:0] FIRST_SLOT = '0;
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(NUM_SLOTS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_CELLS  = 4'd0,
    REG_Y_CELLS  = 4'd1,
    REG_Z_CELLS  = 4'd2,
    REG_PERIODIC = 4'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_CORNER = 2'd0,
    KIND_XMID   = 2'd1,
    KIND_YMID   = 2'd2,
    KIND_ZMID   = 2'd3
  } node_kind_t;

  typedef enum logic [1:0] {
    F_IDLE  = 2'd0,
    F_DIV_X = 2'd1,
    F_DIV_Y = 2'd2,
    F_PUSH  = 2'd3
  } front_state_t;

  typedef struct packed {
    node_kind_t kind;
    logic       di;
    logic       dj;
    logic       dk;
  } slot_info_t;

  function automatic slot_info_t slot_info(input logic [SLOT_W-1:0] s);
    slot_info_t r;
    case (s)
      5'd0:    r = '{KIND_CORNER, 1'b0, 1'b0, 1'b0};
      5'd1:    r = '{KIND_CORNER, 1'b1, 1'b0, 1'b0};
      5'd2:    r = '{KIND_CORNER, 1'b1, 1'b1, 1'b0};
      5'd3:    r = '{KIND_CORNER, 1'b0, 1'b1, 1'b0};
      5'd4:    r = '{KIND_CORNER, 1'b0, 1'b0, 1'b1};
      5'd5:    r = '{KIND_CORNER, 1'b1, 1'b0, 1'b1};
      5'd6:    r = '{KIND_CORNER, 1'b1, 1'b1, 1'b1};
      5'd7:    r = '{KIND_CORNER, 1'b0, 1'b1, 1'b1};
      5'd8:    r = '{KIND_XMID,   1'b0, 1'b0, 1'b0};
      5'd9:    r = '{KIND_YMID,   1'b1, 1'b0, 1'b0};
      5'd10:   r = '{KIND_XMID,   1'b0, 1'b1, 1'b0};
      5'd11:   r = '{KIND_YMID,   1'b0, 1'b0, 1'b0};
      5'd12:   r = '{KIND_XMID,   1'b0, 1'b0, 1'b1};
      5'd13:   r = '{KIND_YMID,   1'b1, 1'b0, 1'b1};
      5'd14:   r = '{KIND_XMID,   1'b0, 1'b1, 1'b1};
      5'd15:   r = '{KIND_YMID,   1'b0, 1'b0, 1'b1};
      5'd16:   r = '{KIND_ZMID,   1'b0, 1'b0, 1'b0};
      5'd17:   r = '{KIND_ZMID,   1'b1, 1'b0, 1'b0};
      5'd18:   r = '{KIND_ZMID,   1'b1, 1'b1, 1'b0};
      5'd19:   r = '{KIND_ZMID,   1'b0, 1'b1, 1'b0};
      default: r = '{KIND_CORNER, 1'b0, 1'b0, 1'b0};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/hexc_if.sv @@
// Channel interfaces of the hex20 connectivity block: element requests,
// node results and configuration writes. Depends on hexc_pkg.
`default_nettype none

interface hexc_elem_if;
  logic                       valid;
  logic                       ready;
  logic [hexc_pkg::IDX_W-1:0] element_index;
  modport source(output valid, output element_index, input ready);
  modport sink(input valid, input element_index, output ready);
endinterface

interface hexc_node_if;
  logic                        valid;
  logic                        ready;
  logic [hexc_pkg::NODE_W-1:0] node_index;
  logic [hexc_pkg::SLOT_W-1:0] node_slot;
  logic                        last_node;
  logic                        range_error;
  modport source(output valid, output node_index, output node_slot, output last_node,
                 output range_error, input ready);
  modport sink(input valid, input node_index, input node_slot, input last_node,
               input range_error, output ready);
endinterface

interface hexc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hexc_pkg::CFG_IDX_W-1:0] index;
  logic [hexc_pkg::CFG_W-1:0]     data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/hexc_cfg.sv @@
// Configuration registers and the derived grid geometry (strides, block bases,
// element count) for the hex20 connectivity block. Depends on hexc_pkg, hexc_if.
`default_nettype none

module hexc_cfg #(
  parameter int MAX_RES = hexc_pkg::MAX_RES_DEF,
  parameter int RES_W   = hexc_pkg::RES_W_DEF
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  hexc_cfg_if.sink                                           cfg,
  output logic [RES_W-1:0]                                   nx,
  output logic [RES_W-1:0]                                   ny,
  output logic [RES_W-1:0]                                   nz,
  output logic                                               periodic,
  output logic [3*RES_W-1:0]                                 ne,
  output logic [hexc_pkg::NUM_KINDS-1:0][hexc_pkg::NODE_W-1:0] cstride,
  output logic [hexc_pkg::NUM_KINDS-1:0][RES_W-1:0]            bstride,
  output logic [hexc_pkg::NUM_KINDS-1:0][hexc_pkg::NODE_W-1:0] base
);

  localparam int P_W  = 2 * RES_W;
  localparam int NE_W = 3 * RES_W;
  localparam int NW   = hexc_pkg::NODE_W;

  logic [hexc_pkg::CFG_W-1:0] x_cells;
  logic [hexc_pkg::CFG_W-1:0] y_cells;
  logic [hexc_pkg::CFG_W-1:0] z_cells;
  logic                       periodic_mode;

  logic [RES_W-1:0] nx1;
  logic [RES_W-1:0] ny1;
  logic [RES_W-1:0] nz1;

  logic [P_W-1:0]   nxny;
  logic [P_W-1:0]   plane;
  logic [P_W-1:0]   nxny1;
  logic [P_W-1:0]   nx1ny;
  logic [RES_W-1:0] nz_s1;
  logic [RES_W-1:0] nz1_s1;
  logic [RES_W-1:0] nx_s1;
  logic [RES_W-1:0] nx1_s1;
  logic             per_s1;

  logic [NE_W-1:0]  ne_full;
  logic [NW-1:0]    ncorner;
  logic [NW-1:0]    nxmid;
  logic [NW-1:0]    nymid;

  function automatic logic [RES_W-1:0] clamp_res(input logic [hexc_pkg::CFG_W-1:0] v);
    if (v == '0) begin
      return RES_W'(1);
    end else if (32'(v) > MAX_RES) begin
      return RES_W'(MAX_RES);
    end else begin
      return RES_W'(v);
    end
  endfunction

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_cells       <= hexc_pkg::CFG_W'(1);
      y_cells       <= hexc_pkg::CFG_W'(1);
      z_cells       <= hexc_pkg::CFG_W'(1);
      periodic_mode <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        hexc_pkg::REG_X_CELLS:  x_cells       <= cfg.data;
        hexc_pkg::REG_Y_CELLS:  y_cells       <= cfg.data;
        hexc_pkg::REG_Z_CELLS:  z_cells       <= cfg.data;
        hexc_pkg::REG_PERIODIC: periodic_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign nx       = clamp_res(x_cells);
  assign ny       = clamp_res(y_cells);
  assign nz       = clamp_res(z_cells);
  assign periodic = periodic_mode;
  assign nx1      = nx + RES_W'(1);
  assign ny1      = ny + RES_W'(1);
  assign nz1      = nz + RES_W'(1);
  assign ne       = ne_full;

  // products of two resolutions
  always_ff @(posedge clk) begin
    nxny   <= P_W'(nx) * P_W'(ny);
    plane  <= P_W'(nx1) * P_W'(ny1);
    nxny1  <= P_W'(nx) * P_W'(ny1);
    nx1ny  <= P_W'(nx1) * P_W'(ny);
    nz_s1  <= nz;
    nz1_s1 <= nz1;
    nx_s1  <= nx;
    nx1_s1 <= nx1;
    per_s1 <= periodic_mode;
  end

  // products of three resolutions
  always_ff @(posedge clk) begin
    ne_full <= NE_W'(nxny) * NE_W'(nz_s1);
    ncorner <= NW'(NE_W'(plane) * NE_W'(nz1_s1));
    nxmid   <= NW'(NE_W'(nxny1) * NE_W'(nz1_s1));
    nymid   <= NW'(NE_W'(nx1ny) * NE_W'(nz1_s1));
  end

  // per-kind strides and block bases
  always_ff @(posedge clk) begin
    if (per_s1) begin
      cstride[hexc_pkg::KIND_CORNER] <= NW'(nxny);
      cstride[hexc_pkg::KIND_XMID]   <= NW'(nxny);
      cstride[hexc_pkg::KIND_YMID]   <= NW'(nxny);
      cstride[hexc_pkg::KIND_ZMID]   <= NW'(nxny);
      bstride[hexc_pkg::KIND_CORNER] <= nx_s1;
      bstride[hexc_pkg::KIND_XMID]   <= nx_s1;
      bstride[hexc_pkg::KIND_YMID]   <= nx_s1;
      bstride[hexc_pkg::KIND_ZMID]   <= nx_s1;
      base[hexc_pkg::KIND_CORNER]    <= '0;
      base[hexc_pkg::KIND_XMID]      <= NW'(ne_full);
      base[hexc_pkg::KIND_YMID]      <= NW'(ne_full) << 1;
      base[hexc_pkg::KIND_ZMID]      <= (NW'(ne_full) << 1) + NW'(ne_full);
    end else begin
      cstride[hexc_pkg::KIND_CORNER] <= NW'(plane);
      cstride[hexc_pkg::KIND_XMID]   <= NW'(nxny1);
      cstride[hexc_pkg::KIND_YMID]   <= NW'(nx1ny);
      cstride[hexc_pkg::KIND_ZMID]   <= NW'(plane);
      bstride[hexc_pkg::KIND_CORNER] <= nx1_s1;
      bstride[hexc_pkg::KIND_XMID]   <= nx_s1;
      bstride[hexc_pkg::KIND_YMID]   <= nx1_s1;
      bstride[hexc_pkg::KIND_ZMID]   <= nx1_s1;
      base[hexc_pkg::KIND_CORNER]    <= '0;
      base[hexc_pkg::KIND_XMID]      <= ncorner;
      base[hexc_pkg::KIND_YMID]      <= ncorner + nxmid;
      base[hexc_pkg::KIND_ZMID]      <= ncorner + nxmid + nymid;
    end
  end

endmodule

`default_nettype wire

@@ sv/hexc_front.sv @@
// Front end: takes element requests, splits the index into cell coordinates
// with a shared radix-16 divider and range-checks it. Depends on hexc_pkg, hexc_if.
`default_nettype none

module hexc_front #(
  parameter int RES_W   = hexc_pkg::RES_W_DEF,
  parameter int NE_W    = 3 * hexc_pkg::RES_W_DEF,
  parameter int ENTRY_W = 3 * hexc_pkg::RES_W_DEF + 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  hexc_elem_if.sink               elem,
  input  wire logic [RES_W-1:0]   nx,
  input  wire logic [RES_W-1:0]   ny,
  input  wire logic [NE_W-1:0]    ne,
  output logic                    push_valid,
  input  wire logic               push_ready,
  output logic [ENTRY_W-1:0]      push_data
);

  localparam int IW    = hexc_pkg::IDX_W;
  localparam int CMP_W = (NE_W > IW) ? NE_W : IW;

  hexc_pkg::front_state_t state;
  hexc_pkg::front_state_t state_next;

  logic [hexc_pkg::CNT_W-1:0] cnt;
  logic [IW-1:0]              idx;
  logic [IW-1:0]              dq;
  logic [RES_W-1:0]           rem;
  logic [RES_W-1:0]           i_val;

  logic [RES_W-1:0] divisor;
  logic [RES_W-1:0] r_step;
  logic [IW-1:0]    q_step;
  logic [RES_W:0]   r_sh;
  logic             cnt_last;
  logic             load;
  logic             div_step;
  logic             oor;

  assign cnt_last = (cnt == hexc_pkg::CNT_W'(hexc_pkg::DIV_CYCLES - 1));
  assign oor      = (CMP_W'(idx) >= CMP_W'(ne));

  // radix-16 restoring step: four quotient bits per cycle
  always_comb begin
    divisor = (state == hexc_pkg::F_DIV_X) ? nx : ny;
    r_step  = rem;
    q_step  = dq;
    r_sh    = '0;
    for (int n = 0; n < hexc_pkg::DIV_STEPS; n++) begin
      r_sh   = {r_step, q_step[IW-1]};
      q_step = {q_step[IW-2:0], 1'b0};
      if (r_sh >= {1'b0, divisor}) begin
        r_sh      = r_sh - {1'b0, divisor};
        q_step[0] = 1'b1;
      end
      r_step = r_sh[RES_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      hexc_pkg::F_IDLE: begin
        if (elem.valid) state_next = hexc_pkg::F_DIV_X;
      end
      hexc_pkg::F_DIV_X: begin
        if (cnt_last) state_next = hexc_pkg::F_DIV_Y;
      end
      hexc_pkg::F_DIV_Y: begin
        if (cnt_last) state_next = hexc_pkg::F_PUSH;
      end
      hexc_pkg::F_PUSH: begin
        if (push_ready) begin
          state_next = elem.valid ? hexc_pkg::F_DIV_X : hexc_pkg::F_IDLE;
        end
      end
      default: state_next = hexc_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    elem.ready = 1'b0;
    push_valid = 1'b0;
    div_step   = 1'b0;
    case (state)
      hexc_pkg::F_IDLE:  elem.ready = 1'b1;
      hexc_pkg::F_DIV_X: div_step   = 1'b1;
      hexc_pkg::F_DIV_Y: div_step   = 1'b1;
      hexc_pkg::F_PUSH: begin
        push_valid = 1'b1;
        elem.ready = push_ready;
      end
      default: ;
    endcase
    load = elem.ready && elem.valid;
  end

  assign push_data = {oor, dq[RES_W-1:0], rem, i_val};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hexc_pkg::F_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (load || (div_step && cnt_last)) begin
        cnt <= '0;
      end else if (div_step) begin
        cnt <= cnt + hexc_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      idx <= elem.element_index;
      dq  <= elem.element_index;
      rem <= '0;
    end else if (div_step) begin
      dq <= q_step;
      if (cnt_last && state == hexc_pkg::F_DIV_X) begin
        i_val <= r_step;
        rem   <= '0;
      end else begin
        rem <= r_step;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/hexc_queue.sv @@
// Small show-ahead queue between the front and back ends of the hex20
// connectivity block. Depends on nothing.
`default_nettype none

module hexc_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire logic [W-1:0] push_data,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output logic [W-1:0]      pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ sv/hexc_back.sv @@
// Back end: walks each queued element's 20 node slots (one if out of range) via a
// three-stage stall pipeline (offsets, products, sum). Depends on hexc_pkg, hexc_if.
`default_nettype none

module hexc_back #(
  parameter int RES_W   = hexc_pkg::RES_W_DEF,
  parameter int ENTRY_W = 3 * hexc_pkg::RES_W_DEF + 1
) (
  input  wire logic                                               clk,
  input  wire logic                                               rst,
  input  wire logic                                               pop_valid,
  output logic                                                    pop_ready,
  input  wire logic [ENTRY_W-1:0]                                 pop_data,
  input  wire logic [RES_W-1:0]                                   nx,
  input  wire logic [RES_W-1:0]                                   ny,
  input  wire logic [RES_W-1:0]                                   nz,
  input  wire logic                                               periodic,
  input  wire logic [hexc_pkg::NUM_KINDS-1:0][hexc_pkg::NODE_W-1:0] cstride,
  input  wire logic [hexc_pkg::NUM_KINDS-1:0][RES_W-1:0]            bstride,
  input  wire logic [hexc_pkg::NUM_KINDS-1:0][hexc_pkg::NODE_W-1:0] base,
  hexc_node_if.source                                             node
);

  localparam int NW = hexc_pkg::NODE_W;
  localparam int SW = hexc_pkg::SLOT_W;

  logic [RES_W-1:0] e_i;
  logic [RES_W-1:0] e_j;
  logic [RES_W-1:0] e_k;
  logic             e_oor;

  logic [SW-1:0]          slot;
  hexc_pkg::slot_info_t   info;
  logic                   issue_last;
  logic                   adv;
  logic [RES_W:0]         a_sum;
  logic [RES_W:0]         b_sum;
  logic [RES_W:0]         c_sum;
  logic [RES_W-1:0]       a_wrap;
  logic [RES_W-1:0]       b_wrap;
  logic [RES_W-1:0]       c_wrap;

  logic                   v1;
  hexc_pkg::node_kind_t   kind1;
  logic [RES_W-1:0]       a1;
  logic [RES_W-1:0]       b1;
  logic [RES_W-1:0]       c1;
  logic [SW-1:0]          slot1;
  logic                   last1;
  logic                   oor1;

  logic                   v2;
  logic [NW-1:0]          pc2;
  logic [NW-1:0]          pb2;
  logic [NW-1:0]          base2;
  logic [RES_W-1:0]       a2;
  logic [SW-1:0]          slot2;
  logic                   last2;
  logic                   oor2;

  logic                   v3;

  assign {e_oor, e_k, e_j, e_i} = pop_data;

  assign adv        = !v3 || node.ready;
  assign info       = hexc_pkg::slot_info(slot);
  assign issue_last = e_oor || (slot == hexc_pkg::LAST_SLOT);
  assign pop_ready  = adv && issue_last;

  // neighbor offsets, wrapped in periodic mode
  always_comb begin
    a_sum  = {1'b0, e_i} + (RES_W + 1)'(info.di);
    b_sum  = {1'b0, e_j} + (RES_W + 1)'(info.dj);
    c_sum  = {1'b0, e_k} + (RES_W + 1)'(info.dk);
    a_wrap = RES_W'(a_sum);
    b_wrap = RES_W'(b_sum);
    c_wrap = RES_W'(c_sum);
    if (periodic && a_sum >= {1'b0, nx}) a_wrap = RES_W'(a_sum - {1'b0, nx});
    if (periodic && b_sum >= {1'b0, ny}) b_wrap = RES_W'(b_sum - {1'b0, ny});
    if (periodic && c_sum >= {1'b0, nz}) c_wrap = RES_W'(c_sum - {1'b0, nz});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= hexc_pkg::FIRST_SLOT;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
    end else if (adv) begin
      if (pop_valid) begin
        slot <= issue_last ? hexc_pkg::FIRST_SLOT : slot + SW'(1);
      end
      v1 <= pop_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind1 <= info.kind;
      a1    <= a_wrap;
      b1    <= b_wrap;
      c1    <= c_wrap;
      slot1 <= slot;
      last1 <= issue_last;
      oor1  <= e_oor;

      pc2   <= NW'((RES_W + NW)'(c1) * (RES_W + NW)'(cstride[kind1]));
      pb2   <= NW'((2 * RES_W)'(b1) * (2 * RES_W)'(bstride[kind1]));
      base2 <= base[kind1];
      a2    <= a1;
      slot2 <= slot1;
      last2 <= last1;
      oor2  <= oor1;

      node.node_index  <= oor2 ? '0 : base2 + pc2 + pb2 + NW'(a2);
      node.node_slot   <= oor2 ? hexc_pkg::FIRST_SLOT : slot2;
      node.last_node   <= last2;
      node.range_error <= oor2;
    end
  end

  assign node.valid = v3;

endmodule

`default_nettype wire

@@ sv/hex20_element_connectivity.sv @@
// Hex20 element connectivity: for each element index request the block returns
// the element's twenty global node indices, slot 0 to 19, one result per cycle
// while the sink is ready, or a single flagged result when the index is at or
// beyond x*y*z cells. Sustained throughput is set by the back end, which emits
// one node per cycle while the sink is ready; the front end makes two passes
// through its radix-16 divider per element and then queues it, so a run of
// out-of-range requests is paced by the front end. Geometry tables are registered
// and settle after a configuration write. Depends on hexc_pkg, hexc_if and all
// hexc_* modules.
`default_nettype none

module hex20_element_connectivity #(
  parameter int MAX_RES = hexc_pkg::MAX_RES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  hexc_cfg_if.sink    cfg,
  hexc_elem_if.sink   elem,
  hexc_node_if.source node
);

  localparam int RES_W   = $clog2(MAX_RES + 2);
  localparam int NE_W    = 3 * RES_W;
  localparam int ENTRY_W = 3 * RES_W + 1;

  logic [RES_W-1:0] nx;
  logic [RES_W-1:0] ny;
  logic [RES_W-1:0] nz;
  logic             periodic;
  logic [NE_W-1:0]  ne;

  logic [hexc_pkg::NUM_KINDS-1:0][hexc_pkg::NODE_W-1:0] cstride;
  logic [hexc_pkg::NUM_KINDS-1:0][RES_W-1:0]            bstride;
  logic [hexc_pkg::NUM_KINDS-1:0][hexc_pkg::NODE_W-1:0] base;

  logic               push_valid;
  logic               push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               pop_valid;
  logic               pop_ready;
  logic [ENTRY_W-1:0] pop_data;

  hexc_cfg #(
    .MAX_RES(MAX_RES),
    .RES_W  (RES_W)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .nx      (nx),
    .ny      (ny),
    .nz      (nz),
    .periodic(periodic),
    .ne      (ne),
    .cstride (cstride),
    .bstride (bstride),
    .base    (base)
  );

  hexc_front #(
    .RES_W  (RES_W),
    .NE_W   (NE_W),
    .ENTRY_W(ENTRY_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .elem      (elem),
    .nx        (nx),
    .ny        (ny),
    .ne        (ne),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  hexc_queue #(
    .W    (ENTRY_W),
    .DEPTH(hexc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  hexc_back #(
    .RES_W  (RES_W),
    .ENTRY_W(ENTRY_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .nx       (nx),
    .ny       (ny),
    .nz       (nz),
    .periodic (periodic),
    .cstride  (cstride),
    .bstride  (bstride),
    .base     (base),
    .node     (node)
  );

endmodule

`default_nettype wire
